// ----- hdl/fadr_pkg.sv -----
// ----------------------------------------------------------------------------
// fadr_pkg
// Shared widths, controller states and the command and status bundles
// of the fraction add and reduce unit.
// ----------------------------------------------------------------------------
package fadr_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_W         = 2 * OPERAND_WIDTH;
    localparam int CNT_W         = $clog2(MAG_W);
    localparam int NUM_OUT_W     = 33;
    localparam int DEN_OUT_W     = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AD,
        ST_MUL_BC,
        ST_MUL_BD,
        ST_SUM,
        ST_EUC_GO,
        ST_EUC_WAIT,
        ST_NUM_GO,
        ST_NUM_WAIT,
        ST_DEN_GO,
        ST_DEN_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_AD,
        MUL_BC,
        MUL_BD
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_EUC,
        DIV_NUM,
        DIV_DEN
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_en;
        logic     div_start;
        div_sel_t div_sel;
        logic     euc_step;
        logic     cap_num;
        logic     cap_den;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic zero_den;
        logic div_done;
        logic rem_zero;
    } status_t;

endpackage

// ----- hdl/fraction_add_reduce_unit.sv -----
// ----------------------------------------------------------------------------
// fraction_add_reduce_unit
// Adds two signed fractions and reduces the sum by its Euclidean gcd.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  first_/second_ numerator, denominator
//   output   out        out_valid/out_stall  sum_numerator, sum_denominator, error
//
// One request at a time. The run time grows with k, the number of Euclid
// remainders; the serial divider (one bit per cycle) sets most of it.
// A zero denominator goes from the first multiply state straight to finish.
// rst_n clears the controller and the output valid flag asynchronously.
// A stalled result holds in the output register while the next request runs.
// ----------------------------------------------------------------------------
module fraction_add_reduce_unit (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [fadr_pkg::OPERAND_WIDTH-1:0] first_numerator,
    input  logic signed [fadr_pkg::OPERAND_WIDTH-1:0] first_denominator,
    input  logic signed [fadr_pkg::OPERAND_WIDTH-1:0] second_numerator,
    input  logic signed [fadr_pkg::OPERAND_WIDTH-1:0] second_denominator,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [fadr_pkg::NUM_OUT_W-1:0]     sum_numerator,
    output logic signed [fadr_pkg::DEN_OUT_W-1:0]     sum_denominator,
    output logic                                      zero_denominator_error
);
    import fadr_pkg::*;

    cmd_t    cmd;
    status_t status;

    fadr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fadr_dp u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .status                 (status),
        .first_numerator        (first_numerator),
        .first_denominator      (first_denominator),
        .second_numerator       (second_numerator),
        .second_denominator     (second_denominator),
        .sum_numerator          (sum_numerator),
        .sum_denominator        (sum_denominator),
        .zero_denominator_error (zero_denominator_error)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not held off after request");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_denominator_error) |->
            (sum_numerator == '0 && sum_denominator == '0))
        else $error("error result carries nonzero value");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !zero_denominator_error) |-> (sum_denominator != '0))
        else $error("reduced denominator is zero");
`endif

endmodule

// ----- hdl/fadr_div.sv -----
// ----------------------------------------------------------------------------
// fadr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fadr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fadr_pkg::MAG_W-1:0] dividend,
    input  logic [fadr_pkg::MAG_W-1:0] divisor,
    output logic [fadr_pkg::MAG_W-1:0] quotient,
    output logic [fadr_pkg::MAG_W-1:0] remainder,
    output logic                       done
);
    import fadr_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] dvs_reg, dvs_next;
    logic [MAG_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[MAG_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = MAG_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[MAG_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- hdl/fadr_dp.sv -----
// ----------------------------------------------------------------------------
// fadr_dp
// Datapath: operand capture, shared multiplier, sum, Euclid registers,
// divider and result registers.
// ----------------------------------------------------------------------------
module fadr_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fadr_pkg::cmd_t                          cmd,
    output fadr_pkg::status_t                       status,
    input  logic signed [fadr_pkg::OPERAND_WIDTH-1:0] first_numerator,
    input  logic signed [fadr_pkg::OPERAND_WIDTH-1:0] first_denominator,
    input  logic signed [fadr_pkg::OPERAND_WIDTH-1:0] second_numerator,
    input  logic signed [fadr_pkg::OPERAND_WIDTH-1:0] second_denominator,
    output logic signed [fadr_pkg::NUM_OUT_W-1:0]   sum_numerator,
    output logic signed [fadr_pkg::DEN_OUT_W-1:0]   sum_denominator,
    output logic                                    zero_denominator_error
);
    import fadr_pkg::*;

    logic signed [OPERAND_WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
    logic signed [MAG_W-1:0]         prod;
    logic signed [MAG_W-1:0]         p_ad_reg, p_bc_reg, p_bd_reg;
    logic signed [MAG_W:0]           sum_w, sum_abs, den_w, den_abs;
    logic [MAG_W-1:0]                num_mag_reg, den_mag_reg;
    logic                            num_neg_reg, den_neg_reg;
    logic [MAG_W-1:0]                xm_reg, ym_reg;
    logic                            xs_reg, ys_reg;
    logic [MAG_W-1:0]                rn_reg, rd_reg;
    logic [MAG_W-1:0]                div_dividend, div_quo, div_rem;
    logic                            div_done;
    logic signed [MAG_W:0]           rn_ext, rd_ext, num_s, den_s;
    logic signed [NUM_OUT_W-1:0]     sum_num_reg;
    logic signed [DEN_OUT_W-1:0]     sum_den_reg;
    logic                            err_reg;
    logic                            zero_den;

    assign zero_den = (b_reg == '0) || (d_reg == '0);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AD:
            begin
                mul_x = a_reg;
                mul_y = d_reg;
            end
            MUL_BC:
            begin
                mul_x = b_reg;
                mul_y = c_reg;
            end
            default:
            begin
                mul_x = b_reg;
                mul_y = d_reg;
            end
        endcase
        prod = mul_x * mul_y;
    end

    always_comb
    begin
        sum_w   = (MAG_W + 1)'(p_ad_reg) + (MAG_W + 1)'(p_bc_reg);
        sum_abs = sum_w[MAG_W] ? -sum_w : sum_w;
        den_w   = (MAG_W + 1)'(p_bd_reg);
        den_abs = den_w[MAG_W] ? -den_w : den_w;
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_EUC: div_dividend = xm_reg;
            DIV_NUM: div_dividend = num_mag_reg;
            default: div_dividend = den_mag_reg;
        endcase
    end

    fadr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (ym_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_comb
    begin
        rn_ext = signed'({1'b0, rn_reg});
        rd_ext = signed'({1'b0, rd_reg});
        num_s  = (num_neg_reg ^ ys_reg) ? -rn_ext : rn_ext;
        den_s  = (den_neg_reg ^ ys_reg) ? -rd_ext : rd_ext;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= first_numerator;
            b_reg <= first_denominator;
            c_reg <= second_numerator;
            d_reg <= second_denominator;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_AD:  p_ad_reg <= prod;
                MUL_BC:  p_bc_reg <= prod;
                default: p_bd_reg <= prod;
            endcase
        end
        if (cmd.sum_en)
        begin
            num_mag_reg <= sum_abs[MAG_W-1:0];
            num_neg_reg <= sum_w[MAG_W];
            den_mag_reg <= den_abs[MAG_W-1:0];
            den_neg_reg <= den_w[MAG_W];
            xm_reg      <= sum_abs[MAG_W-1:0];
            xs_reg      <= sum_w[MAG_W];
            ym_reg      <= den_abs[MAG_W-1:0];
            ys_reg      <= den_w[MAG_W];
        end
        else if (cmd.euc_step)
        begin
            xm_reg <= ym_reg;
            xs_reg <= ys_reg;
            ym_reg <= div_rem;
            ys_reg <= xs_reg;
        end
        if (cmd.cap_num)
        begin
            rn_reg <= div_quo;
        end
        if (cmd.cap_den)
        begin
            rd_reg <= div_quo;
        end
        if (cmd.out_load)
        begin
            err_reg     <= zero_den;
            sum_num_reg <= zero_den ? '0 : NUM_OUT_W'(num_s);
            sum_den_reg <= zero_den ? '0 : DEN_OUT_W'(den_s);
        end
    end

    assign status.zero_den = zero_den;
    assign status.div_done = div_done;
    assign status.rem_zero = (div_rem == '0);

    assign sum_numerator          = sum_num_reg;
    assign sum_denominator        = sum_den_reg;
    assign zero_denominator_error = err_reg;

endmodule

// ----- hdl/fadr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fadr_ctrl
// Controller: sequences multiply, sum, Euclid loop, the two reducing
// divisions and result delivery.
// ----------------------------------------------------------------------------
module fadr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  fadr_pkg::status_t status,
    output fadr_pkg::cmd_t    cmd
);
    import fadr_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_MUL_AD;
            ST_MUL_AD:   state_next = status.zero_den ? ST_FINISH : ST_MUL_BC;
            ST_MUL_BC:   state_next = ST_MUL_BD;
            ST_MUL_BD:   state_next = ST_SUM;
            ST_SUM:      state_next = ST_EUC_GO;
            ST_EUC_GO:   state_next = ST_EUC_WAIT;
            ST_EUC_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = status.rem_zero ? ST_NUM_GO : ST_EUC_GO;
                end
            end
            ST_NUM_GO:   state_next = ST_NUM_WAIT;
            ST_NUM_WAIT: if (status.div_done) state_next = ST_DEN_GO;
            ST_DEN_GO:   state_next = ST_DEN_WAIT;
            ST_DEN_WAIT: if (status.div_done) state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mul_sel = MUL_AD;
        cmd.div_sel = DIV_EUC;
        unique case (state_reg)
            ST_IDLE:     cmd.load = in_valid;
            ST_MUL_AD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AD;
            end
            ST_MUL_BC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BC;
            end
            ST_MUL_BD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BD;
            end
            ST_SUM:      cmd.sum_en = 1'b1;
            ST_EUC_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_EUC;
            end
            ST_EUC_WAIT: cmd.euc_step = status.div_done && !status.rem_zero;
            ST_NUM_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_NUM;
            end
            ST_NUM_WAIT: cmd.cap_num = status.div_done;
            ST_DEN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DEN;
            end
            ST_DEN_WAIT: cmd.cap_den = status.div_done;
            ST_FINISH:   cmd.out_load = out_free;
            default:     cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- tb/sv/fraction_add_reduce_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_reduce_unit_tb
// Drives random and corner-case fraction pairs into the unit, predicts the
// reduced sum with a Euclidean gcd on magnitude and sign, and compares every
// result in order while both sides idle at random for most of the run.
// ----------------------------------------------------------------------------
module fraction_add_reduce_unit_tb;

    import fadr_pkg::*;

    localparam int W = OPERAND_WIDTH;

    typedef struct {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic signed [W-1:0] d;
    } request_t;

    typedef struct {
        logic [NUM_OUT_W-1:0] num;
        logic [DEN_OUT_W-1:0] den;
        logic                 err;
    } sum_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [W-1:0]         first_numerator;
    logic signed [W-1:0]         first_denominator;
    logic signed [W-1:0]         second_numerator;
    logic signed [W-1:0]         second_denominator;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [NUM_OUT_W-1:0] sum_numerator;
    logic signed [DEN_OUT_W-1:0] sum_denominator;
    logic                        zero_denominator_error;

    request_t pending_requests[$];
    sum_t     expected_sums[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       failed;

    fraction_add_reduce_unit u_top (.*);

    function automatic sum_t reduce_sum(request_t r);
        sum_t        s;
        longint      p;
        longint      den;
        bit          nneg;
        bit          dneg;
        bit          xs;
        bit          ys;
        bit          rs;
        longint unsigned nmag;
        longint unsigned dmag;
        longint unsigned xm;
        longint unsigned ym;
        longint unsigned rem;
        longint unsigned qn;
        longint unsigned qd;
        s.num = '0;
        s.den = '0;
        s.err = 1'b0;
        if (r.b == 0 || r.d == 0)
        begin
            s.err = 1'b1;
            return s;
        end
        p    = longint'(r.a) * longint'(r.d) + longint'(r.b) * longint'(r.c);
        den  = longint'(r.b) * longint'(r.d);
        nneg = p < 0;
        dneg = den < 0;
        nmag = nneg ? -p : p;
        dmag = dneg ? -den : den;
        xm = nmag;
        ym = dmag;
        xs = nneg;
        ys = dneg;
        forever
        begin
            rem = xm % ym;
            if (rem == 0)
                break;
            rs = xs;
            xm = ym;
            xs = ys;
            ym = rem;
            ys = rs;
        end
        qn = nmag / ym;
        qd = dmag / ym;
        s.num = NUM_OUT_W'((nneg != ys) ? -qn : qn);
        s.den = DEN_OUT_W'((dneg != ys) ? -qd : qd);
        return s;
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return '0;
            3: return W'($urandom_range(0, 1)) ? W'(1) : '1;
            4, 5: return W'($signed($urandom_range(0, 40)) - 20);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic add_request(int a, int b, int c, int d);
        request_t r;
        r.a = W'(a);
        r.b = W'(b);
        r.c = W'(c);
        r.d = W'(d);
        pending_requests.push_back(r);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("[fraction_add_reduce_unit] ERROR");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid           <= 1'b0;
            first_numerator    <= '0;
            first_denominator  <= '0;
            second_numerator   <= '0;
            second_denominator <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_sums.push_back(reduce_sum('{first_numerator, first_denominator,
                    second_numerator, second_denominator}));
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid           <= 1'b1;
                first_numerator    <= r.a;
                first_denominator  <= r.b;
                second_numerator   <= r.c;
                second_denominator <= r.d;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t unexpected result %h/%h err %b", $time, sum_numerator,
                        sum_denominator, zero_denominator_error);
                    failed = 1'b1;
                end
                else
                begin
                    sum_t e;
                    e = expected_sums.pop_front();
                    if (e.num !== sum_numerator || e.den !== sum_denominator
                        || e.err !== zero_denominator_error)
                    begin
                        $display("%0t expected %0d/%0d err %b, got %0d/%0d err %b", $time,
                            $signed(e.num), $signed(e.den), e.err, sum_numerator,
                            sum_denominator, zero_denominator_error);
                        failed = 1'b1;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        int n;
        failed        = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 70;
        rst_n         = 1'b0;
        add_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        add_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        add_request(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        add_request(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8001);
        add_request(1, 0, 1, 2);
        add_request(1, 2, 1, 0);
        add_request(0, 0, 0, 0);
        add_request(1, 2, -1, 2);
        add_request(0, 5, 0, -7);
        add_request(1, -2, 1, 3);
        add_request(-1, 3, -1, -6);
        add_request(3, 4, 5, 6);
        add_request(-3, 4, 5, -6);
        add_request(1, 1, 1, 1);
        add_request(-1, -1, -1, -1);
        add_request(16'shFFFF, 16'sh8000, 16'sh0001, 16'sh7FFF);
        add_request(12, 18, -8, 27);
        for (int i = 0; i < 1300; i++)
            add_request(pick_operand(), pick_operand(), pick_operand(), pick_operand());
        n = pending_requests.size();
        repeat (2) @(posedge clk);
        rst_n = 1'b1;
        wait (pending_requests.size() <= 2 * n / 3);
        send_idle_pct = 70;
        recv_idle_pct = 26;
        wait (pending_requests.size() <= n / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (in_valid || expected_sums.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (!failed)
            $display("[fraction_add_reduce_unit] OK");
        else
            $display("[fraction_add_reduce_unit] ERROR");
        $finish;
    end

endmodule
